[hw/rtl/smooth_random_modulator_assert.svh]
// ----------------------------------------------------------------------------
// smooth random modulator assertion macros
// shared property forms for the port-level checks, clocked on clk and held
// off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SMOOTH_RANDOM_MODULATOR_ASSERT_SVH
`define SMOOTH_RANDOM_MODULATOR_ASSERT_SVH

// same-cycle implication
`define SRM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srm port check failed");

// next-cycle implication
`define SRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srm port check failed");

`endif

[hw/rtl/srm_pkg.sv]
// ----------------------------------------------------------------------------
// srm_pkg
// payload types, register codes, sequencer states and fixed constants of the
// smooth random modulator
// ----------------------------------------------------------------------------
package srm_pkg;

	// one input item
	typedef struct packed {
		logic signed [14:0] strength_cv;
		logic        [15:0] random_value;
	} req_t;

	// one result item
	typedef struct packed {
		logic signed [14:0] level_mv;
		logic               retargeted;
	} rsp_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD    = 3'd0,
		REG_MIN_LEVEL = 3'd1,
		REG_MAX_LEVEL = 3'd2,
		REG_MAGNET    = 3'd3,
		REG_STRENGTH  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MAG_LOW  = 2'd0,
		MAG_MID  = 2'd1,
		MAG_HIGH = 2'd2
	} magnet_t;

	// register reset values
	localparam logic        [23:0] PERIOD_RST = 24'd48000;
	localparam logic signed [14:0] MIN_RST    = 15'sd0;
	localparam logic signed [14:0] MAX_RST    = 15'sd10000;
	localparam logic        [16:0] SBASE_RST  = 17'd32768;

	// full strength in q0.16
	localparam logic [16:0] STRENGTH_FULL = 17'd65536;

	// output saturation in mV
	localparam logic signed [16:0] LEVEL_MAX = 17'sd10000;
	localparam logic signed [16:0] LEVEL_MIN = -17'sd10000;

	// serial divider: dividend bits and step count
	localparam int DIV_NUM_W  = 27;
	localparam int DIV_STEP_W = 5;

	// cv * 65536 / 10000 == (cv << 12) / 625
	localparam int                    CV_SHIFT     = 12;
	localparam int                    CV_DIVISOR   = 625;
	localparam logic [DIV_STEP_W-1:0] CV_DIV_STEPS = 5'd27;

	typedef struct packed {
		logic                  start;
		logic [DIV_STEP_W-1:0] steps;
	} div_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CV_GO,
		ST_CV_RUN,
		ST_RT_GO,
		ST_RT_RUN,
		ST_DV_GO,
		ST_DV_RUN,
		ST_PP_GO,
		ST_PP_RUN,
		ST_SM_GO,
		ST_SM_RUN,
		ST_BL_GO,
		ST_BL_RUN,
		ST_SC_GO,
		ST_SC_RUN,
		ST_OUT
	} state_t;

endpackage

[hw/rtl/srm_div.sv]
// ----------------------------------------------------------------------------
// srm_div
// bit-serial restoring divider, one quotient bit per cycle, dividend bits
// fed msb first after a preloaded partial remainder
// ----------------------------------------------------------------------------
module srm_div
	import srm_pkg::*;
#(
	parameter int REM_W = 24,
	parameter int QUO_W = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_ctl_t             ctl,
	input  logic [REM_W-1:0]     divisor,
	input  logic [REM_W-1:0]     rem_init,
	input  logic [DIV_NUM_W-1:0] num,
	output logic                 done,
	output logic [QUO_W-1:0]     quotient
);

	logic [REM_W-1:0]      d_q;
	logic [REM_W-1:0]      r_q;
	logic [DIV_NUM_W-1:0]  n_q;
	logic [QUO_W-1:0]      q_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [REM_W:0]   rem_sh;
	logic [REM_W:0]   rem_sub;
	logic             rem_ge;
	logic [REM_W-1:0] rem_next;

	always_comb begin
		rem_sh   = {r_q, n_q[DIV_NUM_W-1]};
		rem_sub  = rem_sh - {1'b0, d_q};
		rem_ge   = rem_sh >= {1'b0, d_q};
		rem_next = rem_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			cnt_q  <= ctl.steps;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_STEP_W'(1);
			if (cnt_q == DIV_STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			d_q <= divisor;
			r_q <= rem_init;
			n_q <= num;
			q_q <= '0;
		end else if (busy_q) begin
			r_q <= rem_next;
			n_q <= {n_q[DIV_NUM_W-2:0], 1'b0};
			q_q <= {q_q[QUO_W-2:0], rem_ge};
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

[hw/rtl/srm_mul.sv]
// ----------------------------------------------------------------------------
// srm_mul
// bit-serial shift-add multiplier, signed multiplicand times unsigned
// multiplier, one multiplier bit per cycle, lsb first
// ----------------------------------------------------------------------------
module srm_mul #(
	parameter int A_W = 19,
	parameter int B_W = 18
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [A_W-1:0]  a,
	input  logic        [B_W-1:0]  b,
	output logic                   done,
	output logic signed [A_W+B_W:0] product
);

	localparam int CW = $clog2(B_W + 1);

	logic signed [A_W-1:0] a_q;
	logic signed [A_W:0]   hi_q;
	logic        [B_W-1:0] lo_q;
	logic        [CW-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic signed [A_W:0] addend;
	logic signed [A_W:0] hi_sum;

	always_comb begin
		addend = lo_q[0] ? {a_q[A_W-1], a_q} : '0;
		hi_sum = hi_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(B_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// partial product shifts right, multiplier bits drop out the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= {hi_sum[A_W], hi_sum[A_W:1]};
			lo_q <= {hi_sum[0], lo_q[B_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = $signed({hi_q, lo_q});

endmodule

[hw/rtl/smooth_random_modulator.sv]
// ----------------------------------------------------------------------------
// smooth_random_modulator
// one smooth random modulation track: a tick counter walks a segment, each
// new segment draws a target pulled toward a magnet point, and the level
// glides along a smoothstep from the old target to the new one, scaled into
// the min/max window in millivolts
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index (register), cfg_data
//  req     | req_valid / req_ready | req_t: strength_cv, random_value
//  rsp     | rsp_valid / rsp_ready | rsp_t: level_mv, retargeted
//
//  an item runs the bit-serial divider for count/period, then the bit-serial
//  multiplier four times in turn (progress squared, smoothstep, blend and
//  window scaling); an item that starts a new segment first divides the
//  strength by 625 (a 27-bit dividend) and forms the target product with the
//  multiplier
//  reset sets the counter, both levels and the config registers to defaults
//  a result waits in the output register; the next item is taken meanwhile
//  and its work only holds in the last state while that register is full
//  cfg_ready is always high; a register write lands at the edge that takes it
//
module smooth_random_modulator
	import srm_pkg::*;
#(
	parameter int FRAC_BITS  = 16,
	parameter int COUNT_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp
);

	// widths of the shared arithmetic
	localparam int F   = FRAC_BITS;
	localparam int CB  = COUNT_BITS;
	localparam int MB  = F + 2;                       // multiplier operand
	localparam int AW  = (F + 3 > 17) ? F + 3 : 17;   // signed multiplicand
	localparam int PW  = AW + MB + 1;                 // product
	localparam int QW  = (F + 1 > 18) ? F + 1 : 18;   // quotient
	localparam int PEW = (CB > 24) ? CB : 24;         // period compare

	localparam logic [63:0] ONE64     = 64'd1 << F;
	localparam logic [63:0] ONE3_64   = 64'd3 << F;
	localparam logic [63:0] CNT_LIM64 = (64'd1 << CB) - 64'd2;

	localparam logic [F:0]    ONE_S  = ONE64[F:0];
	localparam logic [MB-1:0] ONE_B  = ONE64[MB-1:0];
	localparam logic [MB-1:0] ONE3_B = ONE3_64[MB-1:0];
	localparam logic [QW-1:0] ONE_Q  = ONE64[QW-1:0];

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	state_t state_q, state_d;

	// configuration
	logic        [23:0] period_q;
	logic signed [14:0] min_q;
	logic signed [14:0] max_q;
	logic        [1:0]  magnet_q;
	logic        [16:0] sbase_q;

	// track state
	logic [CB-1:0] cnt_q;
	logic [F:0]    start_q;
	logic [F:0]    target_q;

	// current item and intermediate results
	logic signed [14:0] cv_q;
	logic        [15:0] rnd_q;
	logic               rt_q;
	logic [F:0]         s_q;
	logic [F:0]         p_q;
	logic [F:0]         q_q;
	logic [F:0]         sm_q;
	logic [F:0]         y_q;

	// output register
	rsp_t rsp_q;
	logic rsp_valid_q;

	// ------------------------------------------------------------------
	// shared units
	// ------------------------------------------------------------------
	div_ctl_t             div_ctl;
	logic [CB-1:0]        div_divisor;
	logic [CB-1:0]        div_rem_init;
	logic [DIV_NUM_W-1:0] div_num;
	logic                 div_done;
	logic [QW-1:0]        div_quo;

	logic                 mul_start;
	logic signed [AW-1:0] mul_a;
	logic        [MB-1:0] mul_b;
	logic                 mul_done;
	logic signed [PW-1:0] mul_p;

	logic rsp_load;

	srm_div #(
		.REM_W(CB),
		.QUO_W(QW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (div_ctl),
		.divisor (div_divisor),
		.rem_init(div_rem_init),
		.num     (div_num),
		.done    (div_done),
		.quotient(div_quo)
	);

	srm_mul #(
		.A_W(AW),
		.B_W(MB)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.product(mul_p)
	);

	// ------------------------------------------------------------------
	// effective period: clamped to [1, 2^COUNT_BITS - 2] so the counter
	// never wraps
	// ------------------------------------------------------------------
	logic [PEW:0]  period_x;
	logic [PEW:0]  pe_x;
	logic [CB-1:0] pe;
	logic          rt_now;

	always_comb begin
		period_x = {{(PEW + 1 - 24){1'b0}}, period_q};
		if (period_x == '0)
			pe_x = {{PEW{1'b0}}, 1'b1};
		else if (period_x > CNT_LIM64[PEW:0])
			pe_x = CNT_LIM64[PEW:0];
		else
			pe_x = period_x;
		pe     = pe_x[CB-1:0];
		// counter past the period starts a new segment
		rt_now = cnt_q > pe;
	end

	// ------------------------------------------------------------------
	// strength: base + trunc(cv * 65536 / 10000), clamped to [0, full]
	// the divider works on |cv| and the sign is put back afterwards
	// ------------------------------------------------------------------
	logic               cv_neg;
	logic [14:0]        cv_mag;
	logic [17:0]        cv_quo;
	logic signed [19:0] s_sum;
	logic [16:0]        s16;
	logic [F+16:0]      s_scaled;
	logic [F:0]         s_new;

	always_comb begin
		cv_neg = cv_q[14];
		cv_mag = cv_neg ? (~cv_q + 15'd1) : cv_q;
		cv_quo = div_quo[17:0];
		s_sum  = $signed({3'b0, sbase_q})
			+ (cv_neg ? -$signed({2'b0, cv_quo}) : $signed({2'b0, cv_quo}));
		if (s_sum < 0)
			s16 = '0;
		else if (s_sum > $signed({3'b0, STRENGTH_FULL}))
			s16 = STRENGTH_FULL;
		else
			s16 = s_sum[16:0];
		// q0.16 to q0.F, low bits dropped or zero-filled
		s_scaled = {s16, {F{1'b0}}} >> 16;
		s_new    = s_scaled[F:0];
	end

	// ------------------------------------------------------------------
	// new target: (r * (1 - s) + magnet * s) >> F
	// ------------------------------------------------------------------
	logic [F+15:0]  r_scaled;
	logic [F-1:0]   r_val;
	logic [MB-1:0]  one_minus_s;
	logic [2*F+1:0] magnet_term;
	logic [2*F+1:0] target_sum;
	logic [F:0]     target_new;

	always_comb begin
		r_scaled    = {rnd_q, {F{1'b0}}} >> 16;
		r_val       = r_scaled[F-1:0];
		one_minus_s = ONE_B - {1'b0, s_q};
		unique case (magnet_q)
			MAG_MID:  magnet_term = {{(F + 1){1'b0}}, s_q} << (F - 1);
			MAG_HIGH: magnet_term = {{(F + 1){1'b0}}, s_q} << F;
			default:  magnet_term = '0;   // lower magnet and the unused code
		endcase
		target_sum = mul_p[2*F+1:0] + magnet_term;
		target_new = target_sum[2*F:F];
	end

	// ------------------------------------------------------------------
	// progress and smoothstep
	// ------------------------------------------------------------------
	logic [F:0]    p_new;
	logic [MB-1:0] three_minus_2p;
	logic [F+2:0]  sm_full;
	logic [F:0]    sm_new;

	always_comb begin
		p_new          = (div_quo > ONE_Q) ? ONE_S : div_quo[F:0];
		three_minus_2p = ONE3_B - {p_q, 1'b0};
		sm_full        = mul_p[2*F+2:F];
		sm_new         = (sm_full > {2'b0, ONE_S}) ? ONE_S : sm_full[F:0];
	end

	// ------------------------------------------------------------------
	// blend: start + floor((target - start) * sm / ONE)
	// ------------------------------------------------------------------
	logic signed [F+1:0]  lvl_diff;
	logic signed [PW-1:0] prod_sh;
	logic signed [F+2:0]  y_sum;
	logic [F:0]           y_new;

	always_comb begin
		lvl_diff = $signed({1'b0, target_q}) - $signed({1'b0, start_q});
		prod_sh  = mul_p >>> F;
		y_sum    = $signed({2'b0, start_q}) + $signed(prod_sh[F+2:0]);
		if (y_sum[F+2])
			y_new = '0;
		else if (y_sum > $signed({2'b0, ONE_S}))
			y_new = ONE_S;
		else
			y_new = y_sum[F:0];
	end

	// ------------------------------------------------------------------
	// window scaling and saturation
	// ------------------------------------------------------------------
	logic               bounds_swap;
	logic signed [14:0] lo_lvl;
	logic signed [14:0] hi_lvl;
	logic signed [15:0] span_s;
	logic [15:0]        span;
	logic [15:0]        span_part;
	logic signed [16:0] level_raw;
	logic signed [16:0] level_sat;

	always_comb begin
		bounds_swap = min_q > max_q;
		lo_lvl      = bounds_swap ? max_q : min_q;
		hi_lvl      = bounds_swap ? min_q : max_q;
		span_s      = $signed({hi_lvl[14], hi_lvl}) - $signed({lo_lvl[14], lo_lvl});
		span        = span_s;
		span_part   = mul_p[F+15:F];
		level_raw   = $signed({{2{lo_lvl[14]}}, lo_lvl}) + $signed({1'b0, span_part});
		if (level_raw > LEVEL_MAX)
			level_sat = LEVEL_MAX;
		else if (level_raw < LEVEL_MIN)
			level_sat = LEVEL_MIN;
		else
			level_sat = level_raw;
	end

	// ------------------------------------------------------------------
	// unit operands, selected by the sequencer state
	// ------------------------------------------------------------------
	always_comb begin
		if (state_q == ST_DV_GO) begin
			// count << F over the period; the counter never exceeds the
			// period here, so the quotient has F+1 bits
			div_divisor  = pe;
			div_rem_init = cnt_q >> 1;
			div_num      = {cnt_q[0], {(DIV_NUM_W - 1){1'b0}}};
		end else begin
			div_divisor  = CB'(CV_DIVISOR);
			div_rem_init = '0;
			div_num      = {cv_mag, {CV_SHIFT{1'b0}}};
		end
	end

	always_comb begin
		unique case (state_q)
			ST_RT_GO: begin
				mul_a = $signed({{(AW - F){1'b0}}, r_val});
				mul_b = one_minus_s;
			end
			ST_PP_GO: begin
				mul_a = $signed({{(AW - F - 1){1'b0}}, p_q});
				mul_b = {1'b0, p_q};
			end
			ST_SM_GO: begin
				mul_a = $signed({{(AW - F - 1){1'b0}}, q_q});
				mul_b = three_minus_2p;
			end
			ST_BL_GO: begin
				mul_a = {{(AW - F - 2){lvl_diff[F+1]}}, lvl_diff};
				mul_b = {1'b0, sm_q};
			end
			default: begin
				// window scaling
				mul_a = $signed({{(AW - 16){1'b0}}, span});
				mul_b = {1'b0, y_q};
			end
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (req_valid) state_d = rt_now ? ST_CV_GO : ST_DV_GO;
			ST_CV_GO:  state_d = ST_CV_RUN;
			ST_CV_RUN: if (div_done) state_d = ST_RT_GO;
			ST_RT_GO:  state_d = ST_RT_RUN;
			ST_RT_RUN: if (mul_done) state_d = ST_DV_GO;
			ST_DV_GO:  state_d = ST_DV_RUN;
			ST_DV_RUN: if (div_done) state_d = ST_PP_GO;
			ST_PP_GO:  state_d = ST_PP_RUN;
			ST_PP_RUN: if (mul_done) state_d = ST_SM_GO;
			ST_SM_GO:  state_d = ST_SM_RUN;
			ST_SM_RUN: if (mul_done) state_d = ST_BL_GO;
			ST_BL_GO:  state_d = ST_BL_RUN;
			ST_BL_RUN: if (mul_done) state_d = ST_SC_GO;
			ST_SC_GO:  state_d = ST_SC_RUN;
			ST_SC_RUN: if (mul_done) state_d = ST_OUT;
			ST_OUT:    if (!rsp_valid_q || rsp_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer: outputs
	// ------------------------------------------------------------------
	always_comb begin
		req_ready     = 1'b0;
		div_ctl.start = 1'b0;
		div_ctl.steps = CV_DIV_STEPS;
		mul_start     = 1'b0;
		rsp_load      = 1'b0;
		unique case (state_q)
			ST_IDLE:  req_ready = 1'b1;
			ST_CV_GO: div_ctl.start = 1'b1;
			ST_DV_GO: begin
				div_ctl.start = 1'b1;
				div_ctl.steps = DIV_STEP_W'(F + 1);
			end
			ST_RT_GO, ST_PP_GO, ST_SM_GO, ST_BL_GO, ST_SC_GO: mul_start = 1'b1;
			ST_OUT:   rsp_load = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// control and track state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= PERIOD_RST;
			min_q       <= MIN_RST;
			max_q       <= MAX_RST;
			magnet_q    <= MAG_LOW;
			sbase_q     <= SBASE_RST;
			cnt_q       <= '0;
			start_q     <= '0;
			target_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// register writes; unknown indexes fall through
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_PERIOD:    period_q <= cfg_data;
					REG_MIN_LEVEL: min_q    <= cfg_data[14:0];
					REG_MAX_LEVEL: max_q    <= cfg_data[14:0];
					REG_MAGNET:    magnet_q <= cfg_data[1:0];
					REG_STRENGTH:  sbase_q  <= cfg_data[16:0];
					default: ;
				endcase
			end

			// new segment: counter restarts, old target becomes the start
			if (req_valid && req_ready && rt_now) begin
				cnt_q   <= '0;
				start_q <= target_q;
			end

			if (state_q == ST_RT_RUN && mul_done)
				target_q <= target_new;

			if (rsp_load)
				cnt_q <= cnt_q + CB'(1);

			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// item payload and intermediate results
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cv_q  <= req.strength_cv;
			rnd_q <= req.random_value;
			rt_q  <= rt_now;
		end
		if (state_q == ST_CV_RUN && div_done)
			s_q <= s_new;
		if (state_q == ST_DV_RUN && div_done)
			p_q <= p_new;
		if (state_q == ST_PP_RUN && mul_done)
			q_q <= mul_p[2*F:F];
		if (state_q == ST_SM_RUN && mul_done)
			sm_q <= sm_new;
		if (state_q == ST_BL_RUN && mul_done)
			y_q <= y_new;
		// scaling product still sits in the multiplier
		if (rsp_load) begin
			rsp_q.level_mv   <= level_sat[14:0];
			rsp_q.retargeted <= rt_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hw/rtl/srm_chk.sv]
// ----------------------------------------------------------------------------
// srm_chk
// port-level checks for the smooth random modulator, bound to the top level
// ----------------------------------------------------------------------------
`include "smooth_random_modulator_assert.svh"

module srm_chk
	import srm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  req_valid,
	input logic                  req_ready,
	input req_t                  req,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input rsp_t                  rsp
);

	// a stalled result holds
	`SRM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// one item in work at a time
	`SRM_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)

	// a fresh result comes as the work of the last item ends
	`SRM_ASSERT_SAME(a_rsp_after_work, $rose(rsp_valid), req_ready && $past(!req_ready))

	// output stays inside plus or minus 10 V
	`SRM_ASSERT_SAME(a_level_range, rsp_valid, ($signed(rsp.level_mv) <= 15'sd10000) && ($signed(rsp.level_mv) >= -15'sd10000))

endmodule

bind smooth_random_modulator srm_chk u_srm_chk (.*);

[verif/srm_level_checker.sv]
// ----------------------------------------------------------------------------
// srm_level_checker
// tracks register writes and accepted ticks, predicts the level of each tick
// and compares it against the results leaving the modulator in order
// ----------------------------------------------------------------------------
module srm_level_checker
	import srm_pkg::*;
#(
	parameter int FRAC_BITS  = 16,
	parameter int COUNT_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  req_t                  req,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  rsp_t                  rsp,
	output int                    mismatches,
	output int                    outstanding,
	output int                    ticks_checked,
	output int                    segments_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned ONE        = 64'd1 << FRAC_BITS;
	localparam longint unsigned PERIOD_TOP = (64'd1 << COUNT_BITS) - 2;
	localparam longint unsigned COUNT_MASK = (64'd1 << COUNT_BITS) - 1;
	localparam longint unsigned LEVEL_MASK = (64'd1 << (FRAC_BITS + 1)) - 1;
	localparam longint          CV_FULL_MV = 10000;
	localparam int              REPORT_CAP = 40;

	// register copy
	logic        [23:0] period;
	logic signed [14:0] bound_a;
	logic signed [14:0] bound_b;
	logic        [1:0]  magnet;
	logic        [16:0] sbase;

	// segment state
	longint unsigned count;
	longint unsigned seg_start;
	longint unsigned seg_target;

	rsp_t expected_levels[$];
	rsp_t want;

	function automatic longint unsigned to_frac(longint unsigned v);
		if (FRAC_BITS >= 16)
			return v << (FRAC_BITS - 16);
		return v >> (16 - FRAC_BITS);
	endfunction

	// advances the segment state by one tick and returns its result
	function automatic rsp_t next_level(req_t item);
		longint          cv, pull, lo, hi, lvl;
		longint unsigned pe, s, r, m, p, q, sm, y, span;
		rsp_t            res;
		pe = period;
		if (pe < 1)
			pe = 1;
		if (pe > PERIOD_TOP)
			pe = PERIOD_TOP;
		res.retargeted = 1'b0;
		if (count > pe) begin
			cv = item.strength_cv;
			pull = longint'(sbase) + (cv * longint'(STRENGTH_FULL)) / CV_FULL_MV;
			if (pull < 0)
				pull = 0;
			if (pull > longint'(STRENGTH_FULL))
				pull = STRENGTH_FULL;
			s = to_frac(pull);
			r = to_frac(item.random_value);
			m = (magnet == MAG_MID) ? (ONE >> 1) : (magnet == MAG_HIGH) ? ONE : 0;
			count = 0;
			seg_start = seg_target;
			seg_target = ((r * (ONE - s) + m * s) >> FRAC_BITS) & LEVEL_MASK;
			res.retargeted = 1'b1;
		end
		// smoothstep of count/period
		p = (count << FRAC_BITS) / pe;
		if (p > ONE)
			p = ONE;
		q = (p * p) >> FRAC_BITS;
		sm = (q * (3 * ONE - 2 * p)) >> FRAC_BITS;
		if (sm > ONE)
			sm = ONE;
		y = (seg_start * (ONE - sm) + seg_target * sm) >> FRAC_BITS;
		if (y > ONE)
			y = ONE;
		lo = bound_a;
		hi = bound_b;
		if (lo > hi) begin
			lo = bound_b;
			hi = bound_a;
		end
		span = hi - lo;
		lvl = lo + longint'((y * span) >> FRAC_BITS);
		if (lvl > LEVEL_MAX)
			lvl = LEVEL_MAX;
		if (lvl < LEVEL_MIN)
			lvl = LEVEL_MIN;
		count = (count + 1) & COUNT_MASK;
		res.level_mv = lvl[14:0];
		return res;
	endfunction

	function automatic void note_mismatch();
		mismatches++;
		if (mismatches == REPORT_CAP)
			$display("%0t: further mismatches are counted without detail", $time);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period = PERIOD_RST;
			bound_a = MIN_RST;
			bound_b = MAX_RST;
			magnet = MAG_LOW;
			sbase = SBASE_RST;
			count = 0;
			seg_start = 0;
			seg_target = 0;
			expected_levels.delete();
			mismatches = 0;
			outstanding = 0;
			ticks_checked = 0;
			segments_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PERIOD:    period = cfg_data[23:0];
					REG_MIN_LEVEL: bound_a = cfg_data[14:0];
					REG_MAX_LEVEL: bound_b = cfg_data[14:0];
					REG_MAGNET:    magnet = cfg_data[1:0];
					REG_STRENGTH:  sbase = cfg_data[16:0];
					default:       ;
				endcase
			end
			// results first, so a tick taken at this edge is not matched yet
			if (rsp_valid && rsp_ready) begin
				if (expected_levels.size() == 0) begin
					if (mismatches < REPORT_CAP)
						$display("%0t: result with no tick pending, level %0d retargeted %0b",
							$time, rsp.level_mv, rsp.retargeted);
					note_mismatch();
				end else begin
					want = expected_levels.pop_front();
					ticks_checked++;
					if (want.retargeted)
						segments_seen++;
					if (rsp.level_mv !== want.level_mv) begin
						if (mismatches < REPORT_CAP)
							$display("%0t: level_mv expected %0d actual %0d",
								$time, want.level_mv, rsp.level_mv);
						note_mismatch();
					end
					if (rsp.retargeted !== want.retargeted) begin
						if (mismatches < REPORT_CAP)
							$display("%0t: retargeted expected %0b actual %0b",
								$time, want.retargeted, rsp.retargeted);
						note_mismatch();
					end
				end
			end
			if (req_valid && req_ready)
				expected_levels.push_back(next_level(req));
			outstanding = expected_levels.size();
		end
	end

endmodule

[verif/smooth_random_modulator_test.sv]
// ----------------------------------------------------------------------------
// smooth_random_modulator_test
// drives ticks and register writes into the modulator under random source
// gaps and sink stalls; a checker beside the block predicts every level
// ----------------------------------------------------------------------------
module smooth_random_modulator_test
	import srm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC        = 16;
	localparam int COUNT       = 24;
	localparam int CLK_PERIOD  = 10;
	localparam int RESET_CYCLES = 6;
	localparam int PHASES      = 10;
	localparam int PHASE_TICKS = 103;
	// idle tail after the final drain at the end
	localparam int TAIL_CYCLES = 200;
	localparam int CYCLE_LIMIT = 1000000;

	// magnet code with no meaning of its own, must act as lower
	localparam logic [1:0] MAG_UNUSED = 2'd3;
	localparam int FIRST_UNUSED_IDX = REG_STRENGTH + 1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;

	int mismatches, outstanding, ticks_checked, segments_seen;
	int reg_writes  = 0;
	int settings    = 0;
	int cycle_count = 0;
	int stall_left  = 0;

	// when set, that side runs without gaps for the phase
	bit steady_source = 1'b0;
	bit steady_sink   = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	smooth_random_modulator #(
		.FRAC_BITS (FRAC),
		.COUNT_BITS(COUNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	srm_level_checker #(
		.FRAC_BITS (FRAC),
		.COUNT_BITS(COUNT)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.ticks_checked(ticks_checked),
		.segments_seen(segments_seen)
	);

	// gap length: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t tick_of(int cv, int rnd);
		req_t t;
		t.strength_cv = cv[14:0];
		t.random_value = rnd[15:0];
		return t;
	endfunction

	// random tick: cv spread over the legal range, raw bits and the extremes
	function automatic req_t make_tick();
		int cv, rnd;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: cv = int'($urandom_range(0, 20000)) - 10000;
			4, 5, 6:    cv = $urandom;
			7:          cv = $urandom_range(0, 1) ? 10000 : -10000;
			8:          cv = $urandom_range(0, 1) ? 16383 : -16384;
			default:    cv = int'($urandom_range(0, 20)) - 10;
		endcase
		case ($urandom_range(0, 9))
			0:       rnd = 0;
			1:       rnd = 65535;
			default: rnd = $urandom;
		endcase
		return tick_of(cv, rnd);
	endfunction

	function automatic int pick_bound();
		case ($urandom_range(0, 9))
			0:       return -16384;
			1:       return 16383;
			2:       return -10000;
			3:       return 10000;
			4:       return 0;
			5:       return $urandom;
			default: return int'($urandom_range(0, 20000)) - 10000;
		endcase
	endfunction

	function automatic int pick_period();
		case ($urandom_range(0, 11))
			0:       return 0;
			1:       return 24'hFFFFFF;
			2:       return $urandom_range(100, 300);
			3:       return 1;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic int pick_strength();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return STRENGTH_FULL;
			2:       return 17'h1FFFF;
			default: return $urandom_range(0, STRENGTH_FULL);
		endcase
	endfunction

	// one item on the tick channel; valid stays up across back to back items
	task automatic send_tick(req_t item);
		int gap;
		gap = steady_source ? 0 : pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	// every tick yields a result, so an empty checker queue means idle
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
	endtask

	// full register set; unused bits above each field carry noise
	task automatic apply_setting(int per, int lo_mv, int hi_mv, logic [1:0] mag, int base,
			bit poke_unused);
		logic [31:0] noise;
		drain();
		noise = $urandom;
		write_reg(REG_PERIOD, per[23:0]);
		write_reg(REG_MIN_LEVEL, {noise[8:0], lo_mv[14:0]});
		write_reg(REG_MAX_LEVEL, {noise[17:9], hi_mv[14:0]});
		write_reg(REG_MAGNET, {noise[21:0], mag});
		write_reg(REG_STRENGTH, {noise[31:25], base[16:0]});
		// writes past the last register must change nothing
		if (poke_unused)
			for (int i = FIRST_UNUSED_IDX; i < (1 << CFG_IDX_W); i++)
				write_reg(i[CFG_IDX_W-1:0], $urandom);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// sink side: random stalls, off while steady_sink is set
	always @(negedge clk) begin
		if (stall_left != 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_ready <= 1'b1;
			if (!steady_sink && $urandom_range(0, 2) == 0)
				stall_left <= pick_gap();
		end
	end

	// run-away guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: long period, level sits at the lower bound
		send_tick(tick_of(0, 0));
		send_tick(tick_of(10000, 65535));

		// shortest period, swapped bounds, unused magnet, base above full
		apply_setting(0, 10000, -10000, MAG_UNUSED, 17'h1FFFF, 1'b1);
		send_tick(tick_of(16383, 65535));
		send_tick(tick_of(-16384, 0));
		send_tick(tick_of(10000, 32768));
		send_tick(tick_of(-10000, 1));
		send_tick(tick_of(0, 65535));
		send_tick(tick_of(1, 0));
		send_tick(tick_of(-1, 12345));

		// bounds beyond 10 V so the output saturates, middle magnet, zero strength base
		apply_setting(2, -16384, 16383, MAG_MID, 0, 1'b0);
		send_tick(tick_of(0, 65535));
		send_tick(tick_of(5000, 0));
		send_tick(tick_of(-5000, 65535));
		send_tick(tick_of(10000, 40000));
		send_tick(tick_of(-10000, 20000));
		send_tick(tick_of(0, 65535));

		// largest period, full swing, upper magnet at full strength
		apply_setting(24'hFFFFFF, -10000, 10000, MAG_HIGH, STRENGTH_FULL, 1'b0);
		send_tick(tick_of(0, 0));
		send_tick(tick_of(-10000, 65535));
		send_tick(tick_of(10000, 65535));

		// equal bounds give a flat output whatever the level
		apply_setting(3, 10000, 10000, MAG_LOW, SBASE_RST, 1'b0);
		send_tick(tick_of(-16384, 65535));
		send_tick(tick_of(16383, 0));
		send_tick(tick_of(0, 32768));
		send_tick(tick_of(2000, 1000));
		send_tick(tick_of(-2000, 60000));

		// random phases, some with one side kept busy throughout
		for (int ph = 0; ph < PHASES; ph++) begin
			apply_setting(pick_period(), pick_bound(), pick_bound(),
				$urandom_range(0, 3), pick_strength(), $urandom_range(0, 3) == 0);
			steady_source = (ph % 4 == 1);
			steady_sink = (ph % 4 == 2);
			for (int n = 0; n < PHASE_TICKS; n++)
				send_tick(make_tick());
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("checked %0d ticks, %0d of them starting a new segment", ticks_checked,
			segments_seen);
		$display("%0d register settings applied with %0d register writes", settings,
			reg_writes);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
